>>> rtl/oama_pkg.sv
// ----------------------------------------------------------------------------
// oama_pkg
// Shared types, constants and angular-momentum weight table for the
// orbital angular momentum accumulator.
// ----------------------------------------------------------------------------
package oama_pkg;

   localparam logic [3:0] ORBITALS = 4'd10;

   localparam logic [1:0] DIR_X = 2'd0;
   localparam logic [1:0] DIR_Y = 2'd1;
   localparam logic [1:0] DIR_Z = 2'd2;

   localparam logic [0:0] CSR_DIRECTION     = 1'b0;
   localparam logic [0:0] CSR_ORBITAL_COUNT = 1'b1;

   localparam logic signed [17:0] L_ONE = 18'sd16384;
   localparam logic signed [17:0] L_TWO = 18'sd32768;
   localparam logic signed [17:0] L_SQ3 = 18'sd28378;

   typedef struct packed {
      logic signed [15:0] fr;
      logic signed [15:0] fi;
      logic signed [15:0] sr;
      logic signed [15:0] si;
   } coef_type;

   typedef enum logic [2:0] {
      ST_FR_SI,
      ST_FI_SR,
      ST_FR_SR,
      ST_FI_SI,
      ST_CROSS_W,
      ST_DOT_W,
      ST_ACC_IM
   } step_type;

   typedef struct packed {
      logic     run;
      logic     clear;
      step_type step;
   } unit_ctrl_type;

   // Imaginary part of L[row][col], Q4.14; the diagonal is zero everywhere.
   function automatic logic signed [17:0] l_weight(input logic [1:0] dir,
                                                   input logic [3:0] row,
                                                   input logic [3:0] col);
      logic signed [17:0] w;
      logic [7:0]         rc;
      begin
         w  = '0;
         rc = {row, col};
         case (dir)
            DIR_X: begin
               case (rc)
                  8'h34:   w = -L_ONE;
                  8'h43:   w = L_ONE;
                  8'h57:   w = -L_ONE;
                  8'h68:   w = -L_ONE;
                  8'h69:   w = -L_SQ3;
                  8'h75:   w = L_ONE;
                  8'h86:   w = L_ONE;
                  8'h96:   w = L_SQ3;
                  default: w = '0;
               endcase
            end
            DIR_Y: begin
               case (rc)
                  8'h24:   w = L_ONE;
                  8'h42:   w = -L_ONE;
                  8'h56:   w = L_ONE;
                  8'h65:   w = -L_ONE;
                  8'h78:   w = -L_ONE;
                  8'h79:   w = L_SQ3;
                  8'h87:   w = L_ONE;
                  8'h97:   w = -L_SQ3;
                  default: w = '0;
               endcase
            end
            DIR_Z: begin
               case (rc)
                  8'h23:   w = -L_ONE;
                  8'h32:   w = L_ONE;
                  8'h58:   w = L_TWO;
                  8'h67:   w = L_ONE;
                  8'h76:   w = -L_ONE;
                  8'h85:   w = -L_TWO;
                  default: w = '0;
               endcase
            end
            default: w = '0;
         endcase
         return w;
      end
   endfunction

endpackage

>>> rtl/orbital_angular_momentum_accum_top.sv
// ----------------------------------------------------------------------------
// orbital_angular_momentum_accum_top
// Accumulates the angular-momentum expectation of two coefficient streams.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one orbital's coefficient pair per beat (Q1.15), groups of
//   orbital_count beats per atom and spin. req_last_item closes the vector.
//   rsp_* returns one beat per vector: the saturated 64-bit complex sum.
//   csr_* writes direction (index 0) and orbital_count (index 1) while
//   idle; the user must keep to this, the block does not enforce it.
// Scheduling:
//   An item at group position p scans its lower partner orbitals twice,
//   once per weight orientation; each partner with a nonzero weight runs
//   the multiply/add steps on the single shared multiplier and adder.
//   req_ready is high only between items.
// Output:
//   The result sits in an output register; the next item is taken while it
//   waits. A second result waits in wrap-up until the first beat is taken.
// Reset:
//   Clears sums and group position; direction returns to z, count to 10.
// ----------------------------------------------------------------------------
module orbital_angular_momentum_accum_top
   import oama_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_first_re,
   input  logic signed [15:0] req_first_im,
   input  logic signed [15:0] req_second_re,
   input  logic signed [15:0] req_second_im,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_sum_re,
   output logic signed [63:0] rsp_sum_im,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [3:0]         csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_FIN
   } state_type;

   state_type          state_ff;
   logic [1:0]         dir_ff;
   logic [3:0]         cnt_ff;
   logic [3:0]         pos_ff;
   logic [3:0]         p_ff;
   logic [3:0]         k_ff;
   logic               phase_ff;
   logic               last_ff;
   coef_type           cur_ff;
   logic signed [17:0] w_ff;
   step_type           step_ff;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_re_ff;
   logic [63:0]        rsp_im_ff;

   logic [3:0]         cnt_use;
   logic [3:0]         p_in;
   logic [4:0]         p_next;
   logic               accept;
   coef_type           item;
   logic signed [17:0] w_scan;
   logic               rd_en;
   logic               emit;
   coef_type           rd_data;
   coef_type           op_a;
   coef_type           op_b;
   unit_ctrl_type      ctrl;
   logic [63:0]        acc_re;
   logic [63:0]        acc_im;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign item   = '{fr: req_first_re, fi: req_first_im,
                     sr: req_second_re, si: req_second_im};

   always_comb begin
      if (cnt_ff == 4'd0) begin
         cnt_use = 4'd1;
      end else if (cnt_ff > ORBITALS) begin
         cnt_use = ORBITALS;
      end else begin
         cnt_use = cnt_ff;
      end
      p_in   = (pos_ff >= cnt_use) ? 4'd0 : pos_ff;
      p_next = {1'b0, p_in} + 5'd1;
   end

   assign w_scan = phase_ff ? l_weight(dir_ff, k_ff, p_ff) : l_weight(dir_ff, p_ff, k_ff);
   assign rd_en  = (state_ff == S_SCAN) && (k_ff != p_ff) && (w_scan != '0);
   assign emit   = (state_ff == S_FIN) && last_ff && (!rsp_valid_ff || rsp_ready);

   assign op_a = phase_ff ? rd_data : cur_ff;
   assign op_b = phase_ff ? cur_ff : rd_data;

   assign ctrl = '{run: (state_ff == S_MUL), clear: emit, step: step_ff};

   oama_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (p_in),
      .wr_data (item),
      .rd_en   (rd_en),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   oama_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .op_a   (op_a),
      .op_b   (op_b),
      .weight (w_ff),
      .acc_re (acc_re),
      .acc_im (acc_im)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dir_ff       <= DIR_Z;
         cnt_ff       <= ORBITALS;
         pos_ff       <= '0;
         p_ff         <= '0;
         k_ff         <= '0;
         phase_ff     <= 1'b0;
         last_ff      <= 1'b0;
         step_ff      <= ST_FR_SI;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DIRECTION:     dir_ff <= csr_wdata[1:0];
               CSR_ORBITAL_COUNT: cnt_ff <= csr_wdata;
               default:           dir_ff <= dir_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !emit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cur_ff   <= item;
                  p_ff     <= p_in;
                  pos_ff   <= (p_next >= {1'b0, cnt_use}) ? 4'd0 : p_next[3:0];
                  last_ff  <= req_last_item;
                  k_ff     <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (k_ff == p_ff) begin
                  if (!phase_ff) begin
                     phase_ff <= 1'b1;
                     k_ff     <= '0;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else if (w_scan != '0) begin
                  w_ff     <= w_scan;
                  step_ff  <= ST_FR_SI;
                  state_ff <= S_MUL;
               end else begin
                  k_ff <= k_ff + 4'd1;
               end
            end
            S_MUL: begin
               if (step_ff == ST_ACC_IM) begin
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= S_SCAN;
               end else begin
                  step_ff <= step_type'(step_ff + 3'd1);
               end
            end
            S_FIN: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (emit) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_re_ff    <= acc_re;
                  rsp_im_ff    <= acc_im;
                  pos_ff       <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sum_re = rsp_re_ff;
   assign rsp_sum_im = rsp_im_ff;

endmodule

>>> rtl/oama_store.sv
// ----------------------------------------------------------------------------
// oama_store
// Group coefficient memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module oama_store
   import oama_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  logic [3:0] wr_addr,
   input  coef_type   wr_data,
   input  logic       rd_en,
   input  logic [3:0] rd_addr,
   output coef_type   rd_data
);

   coef_type mem [0:ORBITALS-1];
   coef_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/oama_unit.sv
// ----------------------------------------------------------------------------
// oama_unit
// Shared 34x18 multiplier with cross/dot sums and one saturating 64-bit
// adder serving both accumulators.
// ----------------------------------------------------------------------------
module oama_unit
   import oama_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  unit_ctrl_type      ctrl,
   input  coef_type           op_a,
   input  coef_type           op_b,
   input  logic signed [17:0] weight,
   output logic [63:0]        acc_re,
   output logic [63:0]        acc_im
);

   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] prod_in;
   logic signed [51:0] prod_ff;
   logic signed [33:0] cross_ff;
   logic signed [33:0] cross_in;
   logic signed [33:0] dot_ff;
   logic signed [33:0] dot_in;
   logic [63:0]        acc_re_ff;
   logic [63:0]        acc_re_in;
   logic [63:0]        acc_im_ff;
   logic [63:0]        acc_im_in;
   logic [63:0]        term;
   logic [63:0]        opa;
   logic [64:0]        sum_w;
   logic [63:0]        sat_sum;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.step)
         ST_FR_SI: begin
            mul_a = 34'(op_a.fr);
            mul_b = 18'(op_b.si);
         end
         ST_FI_SR: begin
            mul_a = 34'(op_a.fi);
            mul_b = 18'(op_b.sr);
         end
         ST_FR_SR: begin
            mul_a = 34'(op_a.fr);
            mul_b = 18'(op_b.sr);
         end
         ST_FI_SI: begin
            mul_a = 34'(op_a.fi);
            mul_b = 18'(op_b.si);
         end
         ST_CROSS_W: begin
            mul_a = cross_ff;
            mul_b = weight;
         end
         ST_DOT_W: begin
            mul_a = dot_ff;
            mul_b = weight;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // term = product * 2^14; the product stays within 48 signed bits
   assign term = {prod_ff[49:0], 14'd0};
   assign opa  = (ctrl.step == ST_ACC_IM) ? acc_im_ff : acc_re_ff;

   always_comb begin
      if (ctrl.step == ST_DOT_W) begin
         sum_w = {opa[63], opa} - {term[63], term};
      end else begin
         sum_w = {opa[63], opa} + {term[63], term};
      end
      if (sum_w[64] != sum_w[63]) begin
         sat_sum = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_sum = sum_w[63:0];
      end
   end

   always_comb begin
      cross_in  = cross_ff;
      dot_in    = dot_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctrl.run) begin
         case (ctrl.step)
            ST_FI_SR:   cross_in = prod_ff[33:0];
            ST_FR_SR:   cross_in = cross_ff - prod_ff[33:0];
            ST_FI_SI:   dot_in = prod_ff[33:0];
            ST_CROSS_W: dot_in = dot_ff + prod_ff[33:0];
            ST_DOT_W:   acc_re_in = sat_sum;
            ST_ACC_IM:  acc_im_in = sat_sum;
            default:    cross_in = cross_ff;
         endcase
      end
      if (ctrl.clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      if (ctrl.run) begin
         prod_ff <= prod_in;
      end
      cross_ff <= cross_in;
      dot_ff   <= dot_in;
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule
